[hw/rtl/aldg_pkg.sv]
// ----------------------------------------------------------------------------
// aldg_pkg: shared types and constants of the audio load detail governor
// Level codes, request kinds, register indexes and the beat layouts that
// pass between the top level and the evaluation logic.
// ----------------------------------------------------------------------------
package aldg_pkg;

  // Detail levels
  typedef enum logic [1:0] {
    LVL_LOW  = 2'd0,
    LVL_MED  = 2'd1,
    LVL_HIGH = 2'd2
  } level_t;

  // Request kinds carried in tuser
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WAIT_MS       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUFFER_SIZE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PLAYBACKS = 3'd4;

  // Register limits and reset values
  localparam logic [9:0]  THR_MIN       = 10'd100;
  localparam logic [9:0]  THR_MAX       = 10'd950;
  localparam logic [9:0]  THR_RESET     = 10'd750;
  localparam logic [14:0] WAIT_MIN      = 15'd100;
  localparam logic [14:0] WAIT_MAX      = 15'd20000;
  localparam logic [14:0] WAIT_RESET    = 15'd5000;
  localparam logic [31:0] BUF_RESET     = 32'd16777216;
  localparam logic [41:0] MEM_LIM_RESET = 42'd12582912000;  // 750 * 16 MiB

  // Governor constants: clip distance in millifeet, times in ms
  localparam logic [17:0] CLIP_START   = 18'd250000;
  localparam logic [4:0]  CLIP_RATE    = 5'd25;
  localparam int unsigned CHECK_PERIOD = 250;

  // Field widths
  localparam int unsigned MEM_SCALED_W = 42;
  localparam int unsigned DELTA_W      = 21;
  localparam int unsigned EVT_LIM_W    = 17;

  // Captured input item, with the scaled memory use and clip step worked out
  typedef struct packed {
    logic                    req_type;
    logic [31:0]             now_ms;
    logic [MEM_SCALED_W-1:0] mem_scaled;  // mem_used * 1000
    logic [DELTA_W-1:0]      delta;       // elapsed_ms * 25
    logic [15:0]             events_playing;
    logic                    has_metadata;
    logic                    is_ambient;
    logic                    ignore_lod;
    logic [23:0]             distance;
  } item_t;

  // Result beat
  typedef struct packed {
    logic        update_done;
    logic        level_changed;
    logic        audible;
    logic [17:0] clip_distance;
    level_t      level;
  } result_t;

  // Limits derived from the configuration registers
  typedef struct packed {
    logic                    enable;
    logic [14:0]             wait_ms;
    logic [MEM_SCALED_W-1:0] mem_limit;   // threshold_permille * buffer_size
    logic                    evt_test;    // max_playbacks != 0
    logic [EVT_LIM_W-1:0]    evt_limit;   // floor(3 * max_playbacks / 2)
  } limits_t;

endpackage

[hw/rtl/aldg_eval.sv]
// ----------------------------------------------------------------------------
// aldg_eval: per-item evaluation of the detail governor
// Works out the overload test, the throttle, the level walk and the query
// answer for one captured item against the current governor state.
// ----------------------------------------------------------------------------
module aldg_eval
  import aldg_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  item_t                 item,
  input  limits_t               lim,
  input  level_t                level,
  input  logic [17:0]           clip,
  input  logic                  was_over,
  input  logic [TIME_BITS-1:0]  below_since,
  input  logic [TIME_BITS-1:0]  last_check,
  output level_t                level_next,
  output logic [17:0]           clip_next,
  output logic                  was_over_next,
  output logic [TIME_BITS-1:0]  below_since_next,
  output logic [TIME_BITS-1:0]  last_check_next,
  output result_t               result
);

  logic [63:0]          now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_check;
  logic [TIME_BITS-1:0] below_tmp;
  logic [TIME_BITS-1:0] since_below;
  logic                 over;
  logic                 run;
  logic                 quiet;
  logic [DELTA_W-1:0]   clip_wide;
  logic [DELTA_W-1:0]   clip_up;
  logic [17:0]          clip_dn;
  level_t               lvl_eval;
  logic [17:0]          clip_eval;

  // Bring time into the governor's time width
  assign now_wide    = {32'd0, item.now_ms};
  assign now_t       = now_wide[TIME_BITS-1:0];
  assign since_check = now_t - last_check;

  // Evaluate an update only when enabled and the check period has passed
  assign run = (item.req_type == REQ_UPDATE) && lim.enable &&
               (since_check >= TIME_BITS'(CHECK_PERIOD));

  // Overload: memory above threshold or too many events playing
  assign over = (item.mem_scaled > lim.mem_limit) ||
                (lim.evt_test && ({1'b0, item.events_playing} >= lim.evt_limit));

  // Mark the time of leaving overload
  assign below_tmp   = (!over && was_over) ? now_t : below_since;
  assign since_below = now_t - below_tmp;
  assign quiet       = !over && (since_below > TIME_BITS'(lim.wait_ms));

  // Clip ramp in both directions
  assign clip_wide = {3'd0, clip};
  assign clip_up   = clip_wide + item.delta;
  assign clip_dn   = (clip_wide > item.delta) ? 18'(clip_wide - item.delta) : 18'd0;

  // Walk the detail level
  always_comb begin
    lvl_eval  = level;
    clip_eval = clip;
    unique case (level)
      LVL_LOW: begin
        clip_eval = 18'd0;
        if (quiet) begin
          lvl_eval = LVL_MED;
        end
      end
      LVL_MED: begin
        if (over) begin
          clip_eval = clip_dn;
          if (clip_dn == 18'd0) begin
            lvl_eval = LVL_LOW;
          end
        end else if (clip_up >= DELTA_W'(CLIP_START)) begin
          clip_eval = CLIP_START;
          lvl_eval  = LVL_HIGH;
        end else begin
          clip_eval = clip_up[17:0];
        end
      end
      default: begin
        // High, and the unused code that acts as high
        if (over) begin
          clip_eval = CLIP_START;
          lvl_eval  = LVL_MED;
        end
      end
    endcase
  end

  // Commit state only for evaluated updates
  always_comb begin
    level_next       = level;
    clip_next        = clip;
    was_over_next    = was_over;
    below_since_next = below_since;
    last_check_next  = last_check;
    if (run) begin
      level_next       = lvl_eval;
      clip_next        = clip_eval;
      was_over_next    = over;
      below_since_next = below_tmp;
      last_check_next  = now_t;
    end
  end

  // Build the result beat
  always_comb begin
    result.level         = level_next;
    result.clip_distance = clip_next;
    result.update_done   = run;
    result.level_changed = run && (lvl_eval != level);
    result.audible       = 1'b1;
    if ((item.req_type == REQ_QUERY) && lim.enable && item.has_metadata &&
        !item.ignore_lod && ((level == LVL_LOW) || (level == LVL_MED)) &&
        item.is_ambient && ({6'd0, clip} <= item.distance)) begin
      result.audible = 1'b0;
    end
  end

endmodule

[hw/rtl/audio_load_detail_governor.sv]
// ----------------------------------------------------------------------------
// audio_load_detail_governor: three-level audio detail governor
// Tracks memory and event load, walks the detail level and ambient clip
// distance on update beats and answers audibility queries.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser: req_type; tdata: fields
//  m_*      | out       | m_tvalid/m_tready  | tdata: result fields
//  cfg_*    | in        | cfg_we             | cfg_index, cfg_data
//
//  One beat per cycle sustained while m_tready stays high. The input register
//  captures each taken beat, the level logic works between it and the result
//  register, and the result register offers the result. The governor state
//  updates in the same cycle each result is registered, so back-to-back beats
//  see each other's effects. Reset restores the state and the configuration
//  registers and clears both valid flags. A stall on m_tready holds the result;
//  s_tready drops only while both stages hold and m_tready is low.
// ----------------------------------------------------------------------------
module audio_load_detail_governor
  import aldg_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // Input stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // now_ms[31:0], elapsed_ms[47:32], mem_used[79:48], events_playing[95:80],
  // has_metadata[96], is_ambient[97], ignore_lod[98], distance[122:99]
  input  logic [127:0]            s_tdata,
  // req_type[0]
  input  logic                    s_tuser,
  // Result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // level[1:0], clip_distance[19:2], audible[20], level_changed[21],
  // update_done[22]
  output logic [23:0]             m_tdata,
  // Configuration writes
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data
);

  // Configuration registers
  logic        enable;
  logic [9:0]  threshold;
  logic [14:0] wait_ms;
  logic [31:0] buffer_size;
  logic [15:0] max_playbacks;
  logic [9:0]  thr_sat;
  logic [14:0] wait_sat;

  // Derived limits
  logic [MEM_SCALED_W-1:0] mem_limit;
  logic                    evt_test;
  logic [EVT_LIM_W-1:0]    evt_limit;
  limits_t                 lim;

  // Pipeline
  logic        in_valid;
  item_t       in_item;
  item_t       item_next;
  logic        out_valid;
  result_t     out_result;
  result_t     result;
  logic        out_free;
  logic        advance;
  logic [41:0] mem_ext;

  // Governor state
  level_t               level;
  logic [17:0]          clip;
  logic                 was_over;
  logic [TIME_BITS-1:0] below_since;
  logic [TIME_BITS-1:0] last_check;
  level_t               level_next;
  logic [17:0]          clip_next;
  logic                 was_over_next;
  logic [TIME_BITS-1:0] below_since_next;
  logic [TIME_BITS-1:0] last_check_next;

  // Clamp written values into range
  always_comb begin
    thr_sat = cfg_data[9:0];
    if (cfg_data[9:0] < THR_MIN) begin
      thr_sat = THR_MIN;
    end else if (cfg_data[9:0] > THR_MAX) begin
      thr_sat = THR_MAX;
    end
    wait_sat = cfg_data[14:0];
    if (cfg_data[14:0] < WAIT_MIN) begin
      wait_sat = WAIT_MIN;
    end else if (cfg_data[14:0] > WAIT_MAX) begin
      wait_sat = WAIT_MAX;
    end
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      threshold     <= THR_RESET;
      wait_ms       <= WAIT_RESET;
      buffer_size   <= BUF_RESET;
      max_playbacks <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:        enable        <= cfg_data[0];
        REG_THRESHOLD:     threshold     <= thr_sat;
        REG_WAIT_MS:       wait_ms       <= wait_sat;
        REG_BUFFER_SIZE:   buffer_size   <= cfg_data;
        REG_MAX_PLAYBACKS: max_playbacks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Register the derived limits, so they follow the configuration in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_limit <= MEM_LIM_RESET;
      evt_test  <= 1'b0;
      evt_limit <= '0;
    end else begin
      mem_limit <= {32'd0, threshold} * {10'd0, buffer_size};
      evt_test  <= (max_playbacks != 16'd0);
      evt_limit <= EVT_LIM_W'(({2'd0, max_playbacks} * 18'd3) >> 1);
    end
  end

  assign lim = {enable, wait_ms, mem_limit, evt_test, evt_limit};

  // Unpack the beat and scale memory use and clip step
  assign mem_ext = {10'd0, s_tdata[79:48]};
  always_comb begin
    item_next.req_type       = s_tuser;
    item_next.now_ms         = s_tdata[31:0];
    item_next.mem_scaled     = (mem_ext << 10) - (mem_ext << 4) - (mem_ext << 3);
    item_next.delta          = DELTA_W'({5'd0, s_tdata[47:32]} * {16'd0, CLIP_RATE});
    item_next.events_playing = s_tdata[95:80];
    item_next.has_metadata   = s_tdata[96];
    item_next.is_ambient     = s_tdata[97];
    item_next.ignore_lod     = s_tdata[98];
    item_next.distance       = s_tdata[122:99];
  end

  // Flow control
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_item <= item_next;
    end
  end

  aldg_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .item             (in_item),
    .lim              (lim),
    .level            (level),
    .clip             (clip),
    .was_over         (was_over),
    .below_since      (below_since),
    .last_check       (last_check),
    .level_next       (level_next),
    .clip_next        (clip_next),
    .was_over_next    (was_over_next),
    .below_since_next (below_since_next),
    .last_check_next  (last_check_next),
    .result           (result)
  );

  // Advance governor state and the result register together
  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= LVL_HIGH;
      clip        <= 18'd0;
      was_over    <= 1'b0;
      below_since <= '0;
      last_check  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        level       <= level_next;
        clip        <= clip_next;
        was_over    <= was_over_next;
        below_since <= below_since_next;
        last_check  <= last_check_next;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
    if (advance) begin
      out_result <= result;
    end
  end

  // Drive the result stream
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_result};

endmodule
